[rtl/core/input_side_convolution_top_assert.svh]
// Assertion macros used by the input-side convolution controller.
`ifndef INPUT_SIDE_CONVOLUTION_TOP_ASSERT_SVH
`define INPUT_SIDE_CONVOLUTION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isc assertion failed");

`endif

[rtl/core/isc_pkg.sv]
// Package with sizes, opcodes and beat types of the input-side convolution.
`default_nettype none

package isc_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 38;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int TC_BITS     = 7;
    localparam int IDX_BITS    = 6;

    localparam logic [TC_BITS-1:0] TC_RESET = 7'd64;

    // Opcodes of an input beat.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                          opcode;
        logic [IDX_BITS-1:0]           tap_index;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       last_out;
    } t_out_item;

    // Control broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                          load;
        logic                          shift;
        logic                          mac;
        logic                          clear;
        logic [TC_BITS-1:0]            tc;
        logic [IDX_BITS-1:0]           idx;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/core/input_side_convolution_top.sv]
// Top level: full convolution with a loaded impulse response, input-side tap chain.
// A sample beat's result goes to the output register when the beat is accepted.
// Throughput: one beat per cycle while the output is taken and no tail is flushing;
// a last sample with N taps in use leaves N-1 sums to flush out of the bottom cell.
// Reset: partial sums clear, tap count returns to 64, output empty; taps hold no value
// until loaded.
`default_nettype none

module input_side_convolution_top #(
    parameter int MAX_TAPS = isc_pkg::MAX_TAPS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire isc_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output isc_pkg::t_out_item               o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [isc_pkg::TC_BITS-1:0] i_cfg_data
);

    isc_pkg::t_cell_ctrl                 w_ctrl;
    logic signed [isc_pkg::SUM_BITS-1:0] w_fwd [MAX_TAPS+1];

    // Controller with the handshakes and the output register.
    isc_ctrl #(
        .MAX_TAPS(MAX_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_head_sum (w_fwd[0]),
        .o_ctrl     (w_ctrl)
    );

    // A zero enters the top of the chain on every shift.
    assign w_fwd[MAX_TAPS] = '0;

    // Row of cells, each handing its updated sum to the one below.
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        isc_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_ctrl),
            .i_fwd  (w_fwd[g+1]),
            .o_fwd  (w_fwd[g])
        );
    end

endmodule

`default_nettype wire

[rtl/core/isc_cell.sv]
// One cell of the tap chain: a coefficient, a partial sum and its multiply-add.
`default_nettype none

module isc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire isc_pkg::t_cell_ctrl                 i_ctrl,
    input  wire logic signed [isc_pkg::SUM_BITS-1:0] i_fwd,
    output logic signed [isc_pkg::SUM_BITS-1:0]      o_fwd
);

    logic signed [isc_pkg::SAMPLE_BITS-1:0] r_tap;
    logic signed [isc_pkg::SUM_BITS-1:0]    r_sum;
    logic signed [isc_pkg::SUM_BITS-1:0]    n_sum;
    logic signed [isc_pkg::PROD_BITS-1:0]   w_prod;
    logic signed [isc_pkg::SUM_BITS-1:0]    w_addend;
    logic                                   w_mac_en;
    logic                                   w_tap_we;

    // The cell takes part in a sample only while it lies below the tap count.
    assign w_mac_en = i_ctrl.mac && (isc_pkg::TC_BITS'(CELL_IDX) < i_ctrl.tc);
    assign w_tap_we = i_ctrl.load && (i_ctrl.idx == isc_pkg::IDX_BITS'(CELL_IDX));

    // Product of the sample and this cell's tap, sign-extended to the sum width.
    assign w_prod   = i_ctrl.value * r_tap;
    assign w_addend = w_mac_en
        ? {{(isc_pkg::SUM_BITS - isc_pkg::PROD_BITS){w_prod[isc_pkg::PROD_BITS-1]}}, w_prod}
        : '0;

    // Updated sum handed down to the neighbor below (or out of the chain).
    assign o_fwd = r_sum + w_addend;

    // Next sum: cleared at the end of a signal, taken from the cell above on a shift, else held.
    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.clear) begin
            n_sum = '0;
        end else if (i_ctrl.shift) begin
            n_sum = i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // Coefficient store, written by a load beat that addresses this cell.
    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap <= i_ctrl.value;
        end
    end

endmodule

`default_nettype wire

[rtl/core/isc_ctrl.sv]
// Controller: handshakes, tap count register, tail flush counter and output register.
`default_nettype none

`include "input_side_convolution_top_assert.svh"

module isc_ctrl #(
    parameter int MAX_TAPS = isc_pkg::MAX_TAPS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire isc_pkg::t_in_item                   i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output isc_pkg::t_out_item                       o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [isc_pkg::TC_BITS-1:0]         i_cfg_data,
    input  wire logic signed [isc_pkg::SUM_BITS-1:0] i_head_sum,
    output isc_pkg::t_cell_ctrl                      o_ctrl
);

    logic [isc_pkg::TC_BITS-1:0] r_tc;
    logic [isc_pkg::TC_BITS-1:0] w_tc;
    logic [isc_pkg::TC_BITS-1:0] r_flush_cnt;
    logic [isc_pkg::TC_BITS-1:0] n_flush_cnt;
    logic                        r_out_valid;
    isc_pkg::t_out_item          r_out;
    logic                        w_flushing;
    logic                        w_out_free;
    logic                        w_in_beat;
    logic                        w_sample_beat;
    logic                        w_load_beat;
    logic                        w_flush_beat;
    logic                        w_single;
    logic                        w_flush_done;

    // Configuration is to be written only while idle; the block does not enforce this, so the port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= isc_pkg::TC_RESET;
        end else if (i_cfg_valid) begin
            r_tc <= i_cfg_data;
        end
    end

    // Tap count in use: zero acts as one, anything above the chain length as the length.
    always_comb begin
        if (r_tc == '0) begin
            w_tc = isc_pkg::TC_BITS'(1);
        end else if (r_tc > isc_pkg::TC_BITS'(MAX_TAPS)) begin
            w_tc = isc_pkg::TC_BITS'(MAX_TAPS);
        end else begin
            w_tc = r_tc;
        end
    end

    // Beat decoding; input stalls while the tail is flushed or the output is full.
    assign w_flushing    = (r_flush_cnt != '0);
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready    = !w_flushing && w_out_free;
    assign w_in_beat     = i_in_valid && o_in_ready;
    assign w_sample_beat = w_in_beat && (i_in_data.opcode == isc_pkg::OP_SAMPLE);
    assign w_load_beat   = w_in_beat && (i_in_data.opcode == isc_pkg::OP_LOAD);
    assign w_flush_beat  = w_flushing && w_out_free;
    assign w_single      = (w_tc == isc_pkg::TC_BITS'(1));
    assign w_flush_done  = w_flush_beat && (r_flush_cnt == isc_pkg::TC_BITS'(1));

    // Control for the cell chain.
    always_comb begin
        o_ctrl.load  = w_load_beat;
        o_ctrl.shift = w_sample_beat || w_flush_beat;
        o_ctrl.mac   = w_sample_beat;
        o_ctrl.clear = (w_sample_beat && i_in_data.last_sample && w_single) || w_flush_done;
        o_ctrl.tc    = w_tc;
        o_ctrl.idx   = i_in_data.tap_index;
        o_ctrl.value = i_in_data.value;
    end

    // Tail counter: a last sample leaves tap count minus one sums to flush.
    always_comb begin
        n_flush_cnt = r_flush_cnt;
        if (w_sample_beat && i_in_data.last_sample && !w_single) begin
            n_flush_cnt = w_tc - isc_pkg::TC_BITS'(1);
        end else if (w_flush_beat) begin
            n_flush_cnt = r_flush_cnt - isc_pkg::TC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_cnt <= '0;
        end else begin
            r_flush_cnt <= n_flush_cnt;
        end
    end

    // Output register: holds the finished sum that leaves the bottom cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sample_beat || w_flush_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample_beat) begin
            r_out.sum      <= i_head_sum;
            r_out.last_out <= i_in_data.last_sample && w_single;
        end else if (w_flush_beat) begin
            r_out.sum      <= i_head_sum;
            r_out.last_out <= (r_flush_cnt == isc_pkg::TC_BITS'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on the flush sequencing.
    `ISC_ASSERT_NOW(a_flush_stalls_input, i_clk, i_rst_n, w_flushing, !o_in_ready)
    `ISC_ASSERT_NEXT(a_flush_length, i_clk, i_rst_n,
        w_sample_beat && i_in_data.last_sample && !w_single,
        r_flush_cnt == ($past(w_tc) - isc_pkg::TC_BITS'(1)))
    `ISC_ASSERT_NEXT(a_flush_end_marks_last, i_clk, i_rst_n, w_flush_done,
        r_out_valid && r_out.last_out && (r_flush_cnt == '0))
    `ISC_ASSERT_NOW(a_last_only_when_done, i_clk, i_rst_n,
        r_out_valid && r_out.last_out, r_flush_cnt == '0)

endmodule

`default_nettype wire

[bench/isc_conv_checker.sv]
// Checker that predicts the convolution results from the observed beats and compares them.
`timescale 1ns / 100ps

module isc_conv_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  isc_pkg::t_in_item             i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  isc_pkg::t_out_item            i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [isc_pkg::TC_BITS-1:0]   i_cfg_data,
    output int                            o_pending,
    output int                            o_errors
);

    localparam int PRINT_CAP = 100;

    // Shadow copy of the coefficients, the pending sums and the tap count.
    logic signed [isc_pkg::SAMPLE_BITS-1:0] coef [isc_pkg::MAX_TAPS];
    logic [isc_pkg::SUM_BITS-1:0]           acc [isc_pkg::MAX_TAPS];
    logic [isc_pkg::TC_BITS-1:0]            tap_count;
    isc_pkg::t_out_item                     expected_results [$];
    int                                     error_count = 0;

    assign o_errors = error_count;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic flag_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    // A tap count of zero behaves as one, and anything above the maximum as the maximum.
    function automatic int taps_in_use(input logic [isc_pkg::TC_BITS-1:0] tc);
        if (tc == '0) begin
            return 1;
        end
        if (tc > isc_pkg::MAX_TAPS) begin
            return isc_pkg::MAX_TAPS;
        end
        return int'(tc);
    endfunction

    // Adds one sample into every active sum, emits slot zero, shifts, and flushes on last.
    task automatic convolve_sample(input isc_pkg::t_in_item it);
        int                                  n;
        logic signed [isc_pkg::SUM_BITS-1:0] prod;
        isc_pkg::t_out_item                  res;
        n = taps_in_use(tap_count);
        for (int m = 0; m < n; m++) begin
            prod = $signed(it.value) * $signed(coef[m]);
            acc[m] = acc[m] + prod;
        end
        res.sum      = acc[0];
        res.last_out = it.last_sample && (n == 1);
        expected_results.push_back(res);
        // Slots above the active count still move down and come out later.
        for (int m = 0; m < isc_pkg::MAX_TAPS - 1; m++) begin
            acc[m] = acc[m + 1];
        end
        acc[isc_pkg::MAX_TAPS - 1] = '0;
        if (it.last_sample) begin
            for (int m = 0; m + 1 < n; m++) begin
                res.sum      = acc[m];
                res.last_out = (m + 2 == n);
                expected_results.push_back(res);
            end
            for (int m = 0; m < isc_pkg::MAX_TAPS; m++) begin
                acc[m] = '0;
            end
        end
    endtask

    // Watch all three channels at each edge; results are checked before new beats are added.
    always @(posedge i_clk) begin
        isc_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int m = 0; m < isc_pkg::MAX_TAPS; m++) begin
                acc[m] = '0;
            end
            tap_count = isc_pkg::TC_RESET;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result beat with none pending, sum %0d last %0b",
                                            i_out_data.sum, i_out_data.last_out));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.sum !== want.sum) begin
                        flag_mismatch($sformatf("sum %0d, expected %0d",
                                                i_out_data.sum, want.sum));
                    end
                    if (i_out_data.last_out !== want.last_out) begin
                        flag_mismatch($sformatf("last_out %0b, expected %0b",
                                                i_out_data.last_out, want.last_out));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                tap_count = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.opcode == isc_pkg::OP_LOAD) begin
                    coef[i_in_data.tap_index] = i_in_data.value;
                end else begin
                    convolve_sample(i_in_data);
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[bench/tb_input_side_convolution_top.sv]
// Testbench top: drives taps, samples and tap counts into the block and gives the verdict.
`timescale 1ns / 100ps

module tb_input_side_convolution_top;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int LOAD_SETTLE  = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLDOFF_LEN  = 300;
    localparam int STEADY_ITEMS = 120;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CADENCE} t_rx_mode;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    isc_pkg::t_in_item            in_data;
    logic                         out_valid;
    logic                         out_ready;
    isc_pkg::t_out_item           out_data;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [isc_pkg::TC_BITS-1:0]  cfg_data;

    int pending;
    int errors;
    int cycle_count = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    bit steady_send = 1'b0;
    bit holdoff_req = 1'b0;

    input_side_convolution_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    isc_conv_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Clock with a 4 ns period.
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: the run is declared failed if it exceeds the cycle limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Output side: stretches of varying stall patterns, plus one long hold-off on request.
    initial begin
        t_rx_mode mode;
        int       len;
        bit       held;
        held = 1'b0;
        out_ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (holdoff_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                len  = $urandom_range(1, 40);
                for (int c = 0; c < len; c++) begin
                    case (mode)
                        RX_OPEN:   out_ready <= 1'b1;
                        RX_COIN:   out_ready <= 1'($urandom);
                        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                        default:   out_ready <= (c % 3 != 2);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Mostly random values, with the extremes and values near zero mixed in.
    function automatic logic signed [isc_pkg::SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Tap counts lean toward small sizes, with the out-of-range codes in the mix.
    function automatic logic [isc_pkg::TC_BITS-1:0] pick_tap_count();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            4:       return 7'($urandom_range(65, 126));
            5:       return 7'd2;
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    // Offers one input beat, opening a new burst after a random gap when the last one ran out.
    task automatic send_beat(input isc_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_send ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_sample(input logic signed [isc_pkg::SAMPLE_BITS-1:0] val,
                               input logic last);
        isc_pkg::t_in_item it;
        it.opcode      = isc_pkg::OP_SAMPLE;
        it.tap_index   = 6'($urandom);
        it.value       = val;
        it.last_sample = last;
        send_beat(it);
    endtask

    task automatic send_load(input logic [isc_pkg::IDX_BITS-1:0] idx,
                             input logic signed [isc_pkg::SAMPLE_BITS-1:0] val,
                             input logic last);
        isc_pkg::t_in_item it;
        it.opcode      = isc_pkg::OP_LOAD;
        it.tap_index   = idx;
        it.value       = val;
        it.last_sample = last;
        send_beat(it);
    endtask

    // Stops offering beats until every predicted result is out and loads have settled.
    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    // Tap count writes happen only with the block idle.
    task automatic set_tap_count(input logic [isc_pkg::TC_BITS-1:0] tc);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= tc;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Main stimulus: setup loads, directed cases, then random phases.
    initial begin
        int seg_end;
        int kind;
        int n;
        int rand_start;
        int steady_until;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        steady_until = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Load every tap before any sample reads one; the first few hold the extremes.
        for (int k = 0; k < isc_pkg::MAX_TAPS; k++) begin
            send_load(6'(k), (k == 0) ? 16'sh8000 : (k == 1) ? 16'sh7FFF :
                      (k == 2) ? 16'sh0000 : (k == 3) ? 16'shFFFF : 16'($urandom),
                      1'($urandom));
        end

        // Reset tap count of 64 with extreme samples and a full tail flush.
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shFFFF, 1'b1);

        // Single tap: the last sample's own output carries the final flag.
        set_tap_count(7'd1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // A count of zero behaves as one tap.
        set_tap_count(7'd0);
        send_sample(16'sh8000, 1'b1);

        // Counts above the maximum behave as the maximum.
        set_tap_count(7'd127);
        send_sample(16'sh3039, 1'b0);
        send_sample(16'sh8000, 1'b1);
        set_tap_count(7'd65);
        send_sample(16'sh0001, 1'b1);

        set_tap_count(7'd2);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // Lower the count with sums still pending; the upper slots drain out unchanged.
        set_tap_count(7'd8);
        send_sample(16'sh0064, 1'b0);
        send_sample(16'shFF38, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        set_tap_count(7'd3);
        send_sample(16'shFFFB, 1'b0);
        send_sample(16'sh0007, 1'b1);

        // Loads between samples, with the last flag set, which loads ignore.
        send_sample(16'sh0009, 1'b0);
        send_load(6'd1, 16'sh7FFF, 1'b1);
        send_sample(16'shFFF7, 1'b1);
        set_tap_count(7'd64);
        send_load(6'd63, 16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b1);

        // Random phases: mostly whole signals, with stray loads, open-ended runs and lone lasts.
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            if (steady_send && items_sent >= steady_until) begin
                steady_send = 1'b0;
            end
            if (!steady_send) begin
                if ($urandom_range(0, 2) != 0) begin
                    set_tap_count(pick_tap_count());
                end else if ($urandom_range(0, 1) != 0) begin
                    wait_drained();
                end
            end
            // Once, keep offering beats while the output side holds off, so the block backs up.
            if (!holdoff_req && items_sent - rand_start > 200) begin
                holdoff_req  = 1'b1;
                steady_send  = 1'b1;
                steady_until = items_sent + STEADY_ITEMS;
            end
            seg_end = items_sent + $urandom_range(20, 60);
            while (items_sent < seg_end) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6) begin
                    n = $urandom_range(1, 12);
                    for (int s = 0; s < n; s++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            send_load(6'($urandom), 16'($urandom), 1'($urandom));
                        end
                        send_sample(pick_value(), s == n - 1);
                    end
                end else if (kind == 7) begin
                    send_load(6'($urandom), pick_value(), 1'($urandom));
                end else if (kind == 8) begin
                    repeat ($urandom_range(1, 5)) send_sample(pick_value(), 1'b0);
                end else begin
                    send_sample(pick_value(), 1'b1);
                end
            end
        end

        // Drain, allow a few more cycles for stray results, then decide.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
